[rtl/jpc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JPEG pixel colour converter package
// Shared constants, colour mode codes, operand bundle and clamp helper.
// ----------------------------------------------------------------------------
package jpc_pkg;

  localparam int FractionBitsDefault = 16;

  // Width of the unclamped YCbCr result: covers -227 .. 480.
  localparam int WideW = 11;

  typedef enum logic [2:0] {
    MODE_GRAY  = 3'd0,
    MODE_RGB   = 3'd1,
    MODE_YCBCR = 3'd2,
    MODE_CMYK  = 3'd3,
    MODE_YCCK  = 3'd4
  } color_mode_e;

  localparam logic CfgColorMode  = 1'b0;
  localparam logic CfgAdobeMarker = 1'b1;

  typedef struct packed {
    logic signed [WideW-1:0] r;
    logic signed [WideW-1:0] g;
    logic signed [WideW-1:0] b;
  } rgb_wide_t;

  // Operands handed from the first stage to the K product stage.
  typedef struct packed {
    logic [7:0] x_r;
    logic [7:0] x_g;
    logic [7:0] x_b;
    logic [7:0] k;
    logic       use_k;
  } oper_t;

  function automatic logic [7:0] clamp8(input logic signed [WideW-1:0] v);
    logic [7:0] res;
    if (v < 0) begin
      res = 8'd0;
    end else if (v > 255) begin
      res = 8'd255;
    end else begin
      res = v[7:0];
    end
    return res;
  endfunction

endpackage

[rtl/jpeg_pixel_color_to_rgb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JPEG pixel colour converter
// Converts one decoded grayscale, RGB, YCbCr, CMYK or YCCK pixel to RGB.
// ----------------------------------------------------------------------------
// The block accepts one pixel per clock while in_stall_o is low. Each pixel
// passes three registers: an input register, an operand stage that holds the
// YCbCr multipliers, and a result register after the K product multiplier.
// The outputs are driven straight from the result register. Each stage holds
// one beat and moves on as soon as the next stage has room, so the output
// stall reaches the input only when all stages are full. The colour mode and
// Adobe marker registers should be written only while no pixel is in flight;
// the configuration port always accepts a write.
// ----------------------------------------------------------------------------
module jpeg_pixel_color_to_rgb_top #(
  parameter int FractionBits = jpc_pkg::FractionBitsDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic       cfg_index_i,
  input  logic [2:0] cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] comp_a_i,
  input  logic [7:0] comp_b_i,
  input  logic [7:0] comp_c_i,
  input  logic [7:0] comp_d_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] red_o,
  output logic [7:0] green_o,
  output logic [7:0] blue_o
);

  logic [2:0]     color_mode_q;
  logic           adobe_marker_q;

  logic           in_valid_q;
  logic [7:0]     comp_a_q;
  logic [7:0]     comp_b_q;
  logic [7:0]     comp_c_q;
  logic [7:0]     comp_d_q;

  jpc_pkg::oper_t oper_d;
  jpc_pkg::oper_t oper_q;
  logic           oper_valid_q;

  logic           out_valid_q;
  logic [7:0]     red_q;
  logic [7:0]     green_q;
  logic [7:0]     blue_q;
  logic [7:0]     red_d;
  logic [7:0]     green_d;
  logic [7:0]     blue_d;
  logic [7:0]     q_r;
  logic [7:0]     q_g;
  logic [7:0]     q_b;

  logic           out_ready;
  logic           oper_ready;
  logic           in_ready;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_mode_q   <= jpc_pkg::MODE_YCBCR;
      adobe_marker_q <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        jpc_pkg::CfgColorMode:   color_mode_q   <= cfg_wdata_i;
        jpc_pkg::CfgAdobeMarker: adobe_marker_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // A stage can take a beat when it is empty or its contents move on.
  assign out_ready  = !out_valid_q || !out_stall_i;
  assign oper_ready = !oper_valid_q || out_ready;
  assign in_ready   = !in_valid_q || oper_ready;
  assign in_stall_o = !in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q   <= 1'b0;
      oper_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (in_ready) begin
        in_valid_q <= in_valid_i;
      end
      if (oper_ready) begin
        oper_valid_q <= in_valid_q;
      end
      if (out_ready) begin
        out_valid_q <= oper_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && in_valid_i) begin
      comp_a_q <= comp_a_i;
      comp_b_q <= comp_b_i;
      comp_c_q <= comp_c_i;
      comp_d_q <= comp_d_i;
    end
    if (oper_ready && in_valid_q) begin
      oper_q <= oper_d;
    end
    if (out_ready && oper_valid_q) begin
      red_q   <= red_d;
      green_q <= green_d;
      blue_q  <= blue_d;
    end
  end

  jpc_select #(
    .FractionBits(FractionBits)
  ) u_select (
    .color_mode_i  (color_mode_q),
    .adobe_marker_i(adobe_marker_q),
    .comp_a_i      (comp_a_q),
    .comp_b_i      (comp_b_q),
    .comp_c_i      (comp_c_q),
    .comp_d_i      (comp_d_q),
    .oper_o        (oper_d)
  );

  jpc_kmul u_kmul_r (
    .x_i(oper_q.x_r),
    .k_i(oper_q.k),
    .q_o(q_r)
  );

  jpc_kmul u_kmul_g (
    .x_i(oper_q.x_g),
    .k_i(oper_q.k),
    .q_o(q_g)
  );

  jpc_kmul u_kmul_b (
    .x_i(oper_q.x_b),
    .k_i(oper_q.k),
    .q_o(q_b)
  );

  assign red_d   = oper_q.use_k ? q_r : oper_q.x_r;
  assign green_d = oper_q.use_k ? q_g : oper_q.x_g;
  assign blue_d  = oper_q.use_k ? q_b : oper_q.x_b;

  assign out_valid_o = out_valid_q;
  assign red_o       = red_q;
  assign green_o     = green_q;
  assign blue_o      = blue_q;

endmodule

[rtl/jpc_ycc.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JPC YCbCr to RGB
// JFIF equations in fixed point, rounded and floored, without clamping.
// ----------------------------------------------------------------------------
module jpc_ycc #(
  parameter int FractionBits = jpc_pkg::FractionBitsDefault
) (
  input  logic [7:0]        y_i,
  input  logic [7:0]        cb_i,
  input  logic [7:0]        cr_i,
  output jpc_pkg::rgb_wide_t rgb_o
);

  localparam int CoefW = FractionBits + 2;
  localparam int ProdW = CoefW + 9;
  localparam int SumW  = ProdW + 1;
  localparam int W     = jpc_pkg::WideW;

  localparam longint KRcrL = ((64'(1402) << FractionBits) + 500) / 1000;
  localparam longint KGcbL = ((64'(34414) << FractionBits) + 50000) / 100000;
  localparam longint KGcrL = ((64'(71414) << FractionBits) + 50000) / 100000;
  localparam longint KBcbL = ((64'(1772) << FractionBits) + 500) / 1000;

  localparam logic signed [ProdW-1:0] KRcr = ProdW'(KRcrL);
  localparam logic signed [ProdW-1:0] KGcb = ProdW'(KGcbL);
  localparam logic signed [ProdW-1:0] KGcr = ProdW'(KGcrL);
  localparam logic signed [ProdW-1:0] KBcb = ProdW'(KBcbL);
  localparam logic signed [SumW-1:0]  Half = SumW'(64'(1) << (FractionBits - 1));

  logic signed [8:0]       u;
  logic signed [8:0]       v;
  logic signed [ProdW-1:0] u_w;
  logic signed [ProdW-1:0] v_w;
  logic signed [ProdW-1:0] p_rcr;
  logic signed [ProdW-1:0] p_gcb;
  logic signed [ProdW-1:0] p_gcr;
  logic signed [ProdW-1:0] p_bcb;
  logic signed [SumW-1:0]  s_r;
  logic signed [SumW-1:0]  s_g;
  logic signed [SumW-1:0]  s_b;
  logic signed [W-1:0]     y_w;

  assign u   = $signed({1'b0, cb_i}) - 9'sd128;
  assign v   = $signed({1'b0, cr_i}) - 9'sd128;
  assign u_w = ProdW'(u);
  assign v_w = ProdW'(v);

  assign p_rcr = KRcr * v_w;
  assign p_gcb = KGcb * u_w;
  assign p_gcr = KGcr * v_w;
  assign p_bcb = KBcb * u_w;

  assign s_r = SumW'(p_rcr) + Half;
  assign s_g = Half - SumW'(p_gcb) - SumW'(p_gcr);
  assign s_b = SumW'(p_bcb) + Half;

  assign y_w = $signed({3'b000, y_i});

  // Taking the bits above the fraction is the floor of the scaled sum.
  assign rgb_o.r = y_w + $signed(s_r[FractionBits+W-1:FractionBits]);
  assign rgb_o.g = y_w + $signed(s_g[FractionBits+W-1:FractionBits]);
  assign rgb_o.b = y_w + $signed(s_b[FractionBits+W-1:FractionBits]);

endmodule

[rtl/jpc_select.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JPC operand selection
// Per colour mode, forms the three channel operands and the K factor.
// ----------------------------------------------------------------------------
module jpc_select #(
  parameter int FractionBits = jpc_pkg::FractionBitsDefault
) (
  input  logic [2:0]     color_mode_i,
  input  logic           adobe_marker_i,
  input  logic [7:0]     comp_a_i,
  input  logic [7:0]     comp_b_i,
  input  logic [7:0]     comp_c_i,
  input  logic [7:0]     comp_d_i,
  output jpc_pkg::oper_t oper_o
);

  localparam int W = jpc_pkg::WideW;

  jpc_pkg::rgb_wide_t rgb;
  logic [7:0]         a_c;
  logic [7:0]         b_c;
  logic [7:0]         c_c;
  logic [7:0]         d_c;

  jpc_ycc #(
    .FractionBits(FractionBits)
  ) u_ycc (
    .y_i  (comp_a_i),
    .cb_i (comp_b_i),
    .cr_i (comp_c_i),
    .rgb_o(rgb)
  );

  // Without the Adobe marker, CMYK data arrives non-inverted.
  assign a_c = adobe_marker_i ? comp_a_i : ~comp_a_i;
  assign b_c = adobe_marker_i ? comp_b_i : ~comp_b_i;
  assign c_c = adobe_marker_i ? comp_c_i : ~comp_c_i;
  assign d_c = adobe_marker_i ? comp_d_i : ~comp_d_i;

  always_comb begin
    oper_o = '0;
    unique case (color_mode_i)
      jpc_pkg::MODE_GRAY: begin
        oper_o.x_r = comp_a_i;
        oper_o.x_g = comp_a_i;
        oper_o.x_b = comp_a_i;
      end
      jpc_pkg::MODE_RGB: begin
        oper_o.x_r = comp_a_i;
        oper_o.x_g = comp_b_i;
        oper_o.x_b = comp_c_i;
      end
      jpc_pkg::MODE_YCBCR: begin
        oper_o.x_r = jpc_pkg::clamp8(rgb.r);
        oper_o.x_g = jpc_pkg::clamp8(rgb.g);
        oper_o.x_b = jpc_pkg::clamp8(rgb.b);
      end
      jpc_pkg::MODE_CMYK: begin
        oper_o.x_r   = a_c;
        oper_o.x_g   = b_c;
        oper_o.x_b   = c_c;
        oper_o.k     = d_c;
        oper_o.use_k = 1'b1;
      end
      jpc_pkg::MODE_YCCK: begin
        oper_o.x_r   = jpc_pkg::clamp8(W'(255) - rgb.r);
        oper_o.x_g   = jpc_pkg::clamp8(W'(255) - rgb.g);
        oper_o.x_b   = jpc_pkg::clamp8(W'(255) - rgb.b);
        oper_o.k     = comp_d_i;
        oper_o.use_k = 1'b1;
      end
      default: begin
        oper_o = '0;
      end
    endcase
  end

endmodule

[rtl/jpc_kmul.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JPC K product
// Gives floor(x * k / 255) with one 8x8 multiply and a reciprocal fix-up.
// ----------------------------------------------------------------------------
module jpc_kmul (
  input  logic [7:0] x_i,
  input  logic [7:0] k_i,
  output logic [7:0] q_o
);

  logic [15:0] prod;
  logic [16:0] p1;
  logic [16:0] acc;

  assign prod = x_i * k_i;
  // For any 16-bit p, floor(p / 255) equals ((p + 1) + ((p + 1) >> 8)) >> 8.
  assign p1   = {1'b0, prod} + 17'd1;
  assign acc  = p1 + {8'd0, p1[16:8]};
  assign q_o  = acc[15:8];

endmodule
